### hw/rtl/clns_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clns_pkg
// Shared types, command codes and startup tables for the character LCD
// nibble sequencer.
// ----------------------------------------------------------------------------
package clns_pkg;

  typedef enum logic [2:0] {
    REQ_INIT       = 3'd0,
    REQ_WRITE_CHAR = 3'd1,
    REQ_SET_CURSOR = 3'd2,
    REQ_CLEAR      = 3'd3,
    REQ_CLEAR_ROW  = 3'd4
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STARTUP,
    ST_HI,
    ST_LO
  } seq_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic emit_start;
    logic emit_hi;
    logic emit_lo;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic more;
    logic startup_last;
  } status_t;

  localparam logic [7:0] CMD_SET_ADDR   = 8'h80;
  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] CMD_FUNC_4BIT  = 8'h28;
  localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
  localparam logic [7:0] CMD_DISPLAY_ON = 8'h0F;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;

  localparam logic [6:0] WAIT_BYTE  = 7'd1;
  localparam logic [6:0] WAIT_CLEAR = 7'd61;

  localparam logic [4:0] MAX_SPACES     = 5'd16;
  localparam logic [1:0] INIT_LAST_IDX  = 2'd3;

  localparam logic [5:0] VISIBLE_COLUMNS_RESET = 6'd16;
  localparam logic       REG_VISIBLE_COLUMNS   = 1'b0;

  function automatic logic [3:0] startup_nibble(input logic [1:0] idx);
    logic [3:0] nib;
    unique case (idx)
      2'd3:    nib = 4'h2;
      default: nib = 4'h3;
    endcase
    return nib;
  endfunction

  function automatic logic [6:0] startup_wait(input logic [1:0] idx);
    logic [6:0] w;
    unique case (idx)
      2'd0:    w = 7'd5;
      2'd1:    w = 7'd100;
      2'd2:    w = 7'd100;
      default: w = 7'd0;
    endcase
    return w;
  endfunction

  function automatic logic [7:0] init_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = CMD_FUNC_4BIT;
      2'd1:    b = CMD_ENTRY_MODE;
      2'd2:    b = CMD_DISPLAY_ON;
      default: b = CMD_CLEAR;
    endcase
    return b;
  endfunction

endpackage

### hw/rtl/clns_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clns_ctrl
// Sequencer state machine: takes a request, then steps through startup
// nibbles and high/low nibble pairs until the datapath reports no more bytes.
// ----------------------------------------------------------------------------
module clns_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [2:0]         req_type,
  input  clns_pkg::status_t  status,
  output clns_pkg::cmd_t     cmd
);

  clns_pkg::seq_state_t state;
  clns_pkg::seq_state_t state_next;
  logic                 req_ok;

  assign req_ok = (req_type <= clns_pkg::REQ_CLEAR_ROW);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= clns_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      clns_pkg::ST_IDLE: begin
        if (s_tvalid && req_ok) begin
          state_next = (req_type == clns_pkg::REQ_INIT) ? clns_pkg::ST_STARTUP
                                                         : clns_pkg::ST_HI;
        end
      end
      clns_pkg::ST_STARTUP: begin
        if (status.out_free && status.startup_last) begin
          state_next = clns_pkg::ST_HI;
        end
      end
      clns_pkg::ST_HI: begin
        if (status.out_free) begin
          state_next = clns_pkg::ST_LO;
        end
      end
      clns_pkg::ST_LO: begin
        if (status.out_free) begin
          state_next = status.more ? clns_pkg::ST_HI : clns_pkg::ST_IDLE;
        end
      end
      default: state_next = clns_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready       = 1'b0;
    cmd.load       = 1'b0;
    cmd.emit_start = 1'b0;
    cmd.emit_hi    = 1'b0;
    cmd.emit_lo    = 1'b0;
    unique case (state)
      clns_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid && req_ok;
      end
      clns_pkg::ST_STARTUP: cmd.emit_start = status.out_free;
      clns_pkg::ST_HI:      cmd.emit_hi    = status.out_free;
      clns_pkg::ST_LO:      cmd.emit_lo    = status.out_free;
      default: ;
    endcase
  end

  a_single_emit: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.emit_start, cmd.emit_hi, cmd.emit_lo}))
    else $error("more than one transfer issued in a cycle");

  a_end_to_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_lo && !status.more) |=> (state == clns_pkg::ST_IDLE))
    else $error("sequencer did not return to idle after final transfer");

  a_load_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state != clns_pkg::ST_IDLE))
    else $error("accepted request produced no transfers");

endmodule

### hw/rtl/clns_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clns_datapath
// Cursor address, current byte, space counter and the registered output
// transfer, driven by commands from the sequencer.
// ----------------------------------------------------------------------------
module clns_datapath #(
  parameter int ROW2_BASE = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  clns_pkg::cmd_t     cmd,
  output clns_pkg::status_t  status,
  input  logic [2:0]         req_type,
  input  logic [7:0]         data_byte,
  input  logic               row,
  input  logic [5:0]         column,
  input  logic [5:0]         visible_columns,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [3:0]         nibble,
  output logic               reg_select,
  output logic [6:0]         wait_ms,
  output logic               last
);

  localparam logic [7:0] Row2Base = 8'(ROW2_BASE);

  clns_pkg::req_kind_t req;
  logic [6:0]          cursor;
  logic [7:0]          byte_r;
  logic                rs;
  logic [6:0]          wait_r;
  logic [7:0]          end_addr;
  logic [4:0]          cnt;
  logic                in_spaces;

  logic                cur_row;
  logic [7:0]          set_addr;
  logic [7:0]          cr_addr;
  logic [7:0]          cr_end;
  logic                more;

  // clear row re-addresses the row that the cursor is on now
  assign cur_row  = ({1'b0, cursor} >= Row2Base);
  assign set_addr = (row ? Row2Base : 8'd0) + {2'b00, column};
  assign cr_addr  = (cur_row ? Row2Base : 8'd0) + {2'b00, column};
  assign cr_end   = (cur_row ? Row2Base : 8'd0) + {2'b00, visible_columns};

  always_comb begin
    unique case (req)
      clns_pkg::REQ_INIT:      more = (cnt[1:0] != clns_pkg::INIT_LAST_IDX);
      clns_pkg::REQ_CLEAR_ROW: more = ({1'b0, cursor} < end_addr)
                                      && (cnt < clns_pkg::MAX_SPACES);
      default:                 more = 1'b0;
    endcase
  end

  assign status.out_free     = !m_tvalid || m_tready;
  assign status.more         = more;
  assign status.startup_last = (cnt[1:0] == clns_pkg::INIT_LAST_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor    <= '0;
      req       <= clns_pkg::REQ_INIT;
      cnt       <= '0;
      in_spaces <= 1'b0;
    end else if (cmd.load) begin
      req       <= clns_pkg::req_kind_t'(req_type);
      cnt       <= '0;
      in_spaces <= 1'b0;
      rs        <= 1'b0;
      wait_r    <= clns_pkg::WAIT_BYTE;
      end_addr  <= cr_end;
      unique case (req_type)
        clns_pkg::REQ_INIT: begin
          cursor <= '0;
          byte_r <= clns_pkg::init_byte(2'd0);
        end
        clns_pkg::REQ_WRITE_CHAR: begin
          cursor <= cursor + 7'd1;
          byte_r <= data_byte;
          rs     <= 1'b1;
        end
        clns_pkg::REQ_SET_CURSOR: begin
          cursor <= set_addr[6:0];
          byte_r <= clns_pkg::CMD_SET_ADDR | {1'b0, set_addr[6:0]};
        end
        clns_pkg::REQ_CLEAR: begin
          cursor <= '0;
          byte_r <= clns_pkg::CMD_CLEAR;
          wait_r <= clns_pkg::WAIT_CLEAR;
        end
        default: begin
          cursor <= cr_addr[6:0];
          byte_r <= clns_pkg::CMD_SET_ADDR | {1'b0, cr_addr[6:0]};
        end
      endcase
    end else if (cmd.emit_start) begin
      cnt <= status.startup_last ? 5'd0 : cnt + 5'd1;
    end else if (cmd.emit_hi && in_spaces) begin
      // space counted as soon as its first half goes out
      cursor <= cursor + 7'd1;
      cnt    <= cnt + 5'd1;
    end else if (cmd.emit_lo && more) begin
      if (req == clns_pkg::REQ_INIT) begin
        cnt    <= cnt + 5'd1;
        byte_r <= clns_pkg::init_byte(cnt[1:0] + 2'd1);
        wait_r <= ((cnt[1:0] + 2'd1) == clns_pkg::INIT_LAST_IDX) ? clns_pkg::WAIT_CLEAR
                                                                 : clns_pkg::WAIT_BYTE;
      end else begin
        byte_r    <= clns_pkg::CHAR_SPACE;
        rs        <= 1'b1;
        wait_r    <= clns_pkg::WAIT_BYTE;
        in_spaces <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit_start || cmd.emit_hi || cmd.emit_lo) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_start) begin
      nibble     <= clns_pkg::startup_nibble(cnt[1:0]);
      reg_select <= 1'b0;
      wait_ms    <= clns_pkg::startup_wait(cnt[1:0]);
      last       <= 1'b0;
    end else if (cmd.emit_hi) begin
      nibble     <= byte_r[7:4];
      reg_select <= rs;
      wait_ms    <= '0;
      last       <= 1'b0;
    end else if (cmd.emit_lo) begin
      nibble     <= byte_r[3:0];
      reg_select <= rs;
      wait_ms    <= wait_r;
      last       <= !more;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !(cmd.emit_start || cmd.emit_hi || cmd.emit_lo))
    else $error("pending transfer overwritten");

  a_space_limit: assert property (@(posedge clk) disable iff (rst)
    cnt <= clns_pkg::MAX_SPACES)
    else $error("space counter beyond limit");

  a_space_in_row: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_lo && in_spaces) |-> ({1'b0, cursor} <= end_addr))
    else $error("space written past end of row");

endmodule

### hw/rtl/char_lcd_nibble_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_core
// Expands LCD requests into 4-bit bus transfers with register select and
// post-transfer wait, tracking the cursor address.
// ----------------------------------------------------------------------------
// an accepted request first updates the sequencer state; its first transfer is then registered at the output
// throughput: one transfer per cycle while m_tready is high; a request of
//   n transfers (2 to 34) holds off the input until the sequencer has stepped
//   its last nibble into the output register
// unknown request kinds are accepted while idle and produce nothing
// reset: cursor address 0, visible_columns 16, no transfer pending
module char_lcd_nibble_sequencer_core #(
  parameter int ROW2_BASE = 64
) (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // data_byte[7:0], row[8], column[14:9], zero[15]
  input  logic [2:0]  s_tuser,  // req_type[2:0]
  // transfer stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // nibble[3:0], wait_ms[10:4], zero[15:11]
  output logic        m_tuser,  // reg_select
  output logic        m_tlast,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [5:0]         visible_columns;
  clns_pkg::cmd_t     cmd;
  clns_pkg::status_t  status;
  logic [3:0]         nibble;
  logic [6:0]         wait_ms;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      visible_columns <= clns_pkg::VISIBLE_COLUMNS_RESET;
    end else if (psel && penable && pwrite && pready
                 && (paddr[2] == clns_pkg::REG_VISIBLE_COLUMNS)) begin
      visible_columns <= pwdata[5:0];
    end
  end

  assign prdata = (paddr[2] == clns_pkg::REG_VISIBLE_COLUMNS) ? {26'd0, visible_columns}
                                                               : 32'd0;

  clns_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .req_type (s_tuser),
    .status   (status),
    .cmd      (cmd)
  );

  clns_datapath #(
    .ROW2_BASE (ROW2_BASE)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .req_type        (s_tuser),
    .data_byte       (s_tdata[7:0]),
    .row             (s_tdata[8]),
    .column          (s_tdata[14:9]),
    .visible_columns (visible_columns),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .nibble          (nibble),
    .reg_select      (m_tuser),
    .wait_ms         (wait_ms),
    .last            (m_tlast)
  );

  assign m_tdata = {5'd0, wait_ms, nibble};

endmodule

### test/tb_char_lcd_nibble_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_char_lcd_nibble_sequencer_core
// Self-checking bench for the LCD nibble sequencer. A short directed run
// walks init, characters, cursor moves, clears and clear-row corner cases
// under several column widths, then random requests follow with random gaps
// and back-pressure. Every transfer is compared against a cycle-free model
// of the request expansion and the cursor address it tracks.
// ----------------------------------------------------------------------------
module tb_char_lcd_nibble_sequencer_core;

  localparam int ROW2_BASE   = 64;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_PAUSE = 40;

  typedef struct packed {
    logic [3:0] nibble;
    logic       rs;
    logic [6:0] wait_ms;
    logic       last;
  } lcd_xfer_t;

  class lcd_scoreboard;
    lcd_xfer_t  pending_xfers[$];
    logic [6:0] cursor;
    logic [5:0] columns;
    int         mismatches;
    int         xfers_checked;
    int         kind_count[8];

    function new();
      cursor = '0;
      columns = clns_pkg::VISIBLE_COLUMNS_RESET;
      mismatches = 0;
      xfers_checked = 0;
      foreach (kind_count[i]) kind_count[i] = 0;
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("ERROR @%0t: %s", $realtime, what);
    endtask

    function void add_xfer(logic [3:0] nib, logic rs, logic [6:0] w);
      lcd_xfer_t x;
      x.nibble = nib;
      x.rs = rs;
      x.wait_ms = w;
      x.last = 1'b0;
      pending_xfers.push_back(x);
    endfunction

    // high nibble first, the wait only follows the low nibble
    function void add_byte(logic [7:0] b, logic rs, logic [6:0] w);
      add_xfer(b[7:4], rs, 7'd0);
      add_xfer(b[3:0], rs, w);
    endfunction

    function void move_to(logic row, logic [5:0] col);
      cursor = 7'((row ? ROW2_BASE : 0) + int'(col));
      add_byte(clns_pkg::CMD_SET_ADDR | {1'b0, cursor}, 1'b0, clns_pkg::WAIT_BYTE);
    endfunction

    function void note_request(logic [2:0] kind, logic [7:0] data, logic row,
                               logic [5:0] col);
      int   n_prior;
      logic cur_row;
      int   row_end;
      int   spaces;
      n_prior = pending_xfers.size();
      kind_count[kind]++;
      case (kind)
        clns_pkg::REQ_INIT: begin
          // wake-up nibbles, then the 4-bit setup commands
          add_xfer(4'h3, 1'b0, 7'd5);
          add_xfer(4'h3, 1'b0, 7'd100);
          add_xfer(4'h3, 1'b0, 7'd100);
          add_xfer(4'h2, 1'b0, 7'd0);
          add_byte(clns_pkg::CMD_FUNC_4BIT, 1'b0, clns_pkg::WAIT_BYTE);
          add_byte(clns_pkg::CMD_ENTRY_MODE, 1'b0, clns_pkg::WAIT_BYTE);
          add_byte(clns_pkg::CMD_DISPLAY_ON, 1'b0, clns_pkg::WAIT_BYTE);
          add_byte(clns_pkg::CMD_CLEAR, 1'b0, clns_pkg::WAIT_CLEAR);
          cursor = '0;
        end
        clns_pkg::REQ_WRITE_CHAR: begin
          add_byte(data, 1'b1, clns_pkg::WAIT_BYTE);
          cursor = cursor + 7'd1;
        end
        clns_pkg::REQ_SET_CURSOR: move_to(row, col);
        clns_pkg::REQ_CLEAR: begin
          add_byte(clns_pkg::CMD_CLEAR, 1'b0, clns_pkg::WAIT_CLEAR);
          cursor = '0;
        end
        clns_pkg::REQ_CLEAR_ROW: begin
          cur_row = (int'(cursor) >= ROW2_BASE);
          row_end = (cur_row ? ROW2_BASE : 0) + int'(columns);
          move_to(cur_row, col);
          spaces = 0;
          while (int'(cursor) < row_end && spaces < int'(clns_pkg::MAX_SPACES)) begin
            add_byte(clns_pkg::CHAR_SPACE, 1'b1, clns_pkg::WAIT_BYTE);
            cursor = cursor + 7'd1;
            spaces++;
          end
        end
        default: ;
      endcase
      if (pending_xfers.size() > n_prior)
        pending_xfers[pending_xfers.size() - 1].last = 1'b1;
    endfunction

    task check_transfer(lcd_xfer_t got);
      lcd_xfer_t want;
      if (pending_xfers.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer nibble %h rs %0d wait %0d last %0d",
                                  got.nibble, got.rs, got.wait_ms, got.last));
        return;
      end
      want = pending_xfers.pop_front();
      xfers_checked++;
      if (got.nibble !== want.nibble)
        report_mismatch($sformatf("transfer %0d nibble %h, want %h",
                                  xfers_checked, got.nibble, want.nibble));
      if (got.rs !== want.rs)
        report_mismatch($sformatf("transfer %0d reg_select %0d, want %0d",
                                  xfers_checked, got.rs, want.rs));
      if (got.wait_ms !== want.wait_ms)
        report_mismatch($sformatf("transfer %0d wait_ms %0d, want %0d",
                                  xfers_checked, got.wait_ms, want.wait_ms));
      if (got.last !== want.last)
        report_mismatch($sformatf("transfer %0d last %0d, want %0d",
                                  xfers_checked, got.last, want.last));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lcd_scoreboard sb = new();
  lcd_xfer_t seen;
  bit        calm = 1'b0;
  int        quiet_cycles = 0;

  char_lcd_nibble_sequencer_core #(
    .ROW2_BASE(ROW2_BASE)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 30);
  end

  // requests are noted before transfers so a same-edge pair stays in order
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      sb.note_request(s_tuser, s_tdata[7:0], s_tdata[8], s_tdata[14:9]);
    if (!rst && m_tvalid && m_tready) begin
      seen.nibble = m_tdata[3:0];
      seen.rs = m_tuser;
      seen.wait_ms = m_tdata[10:4];
      seen.last = m_tlast;
      sb.check_transfer(seen);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", quiet_cycles);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // entered and left at a falling edge; valid stays high after acceptance
  task send_request(logic [2:0] kind, logic [7:0] data, logic row, logic [5:0] col);
    int gap;
    if (!calm && $urandom_range(0, 99) < 30) begin
      s_tvalid = 1'b0;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = kind;
    s_tdata = {1'b0, col, row, data};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task settle();
    s_tvalid = 1'b0;
    while (sb.pending_xfers.size() != 0) @(negedge clk);
    // unknown kinds leave nothing to wait for, so give the core time to go idle
    repeat (DRAIN_PAUSE) @(negedge clk);
  endtask

  task write_columns(logic [5:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = 3'(4 * clns_pkg::REG_VISIBLE_COLUMNS);
    pwdata = {26'd0, value};
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    sb.columns = value;
  endtask

  task run_random(int n_items);
    int         done;
    int         p;
    logic [2:0] kind;
    logic [5:0] col;
    done = 0;
    while (done < n_items) begin
      p = $urandom_range(0, 99);
      if (p < 6) kind = clns_pkg::REQ_INIT;
      else if (p < 40) kind = clns_pkg::REQ_WRITE_CHAR;
      else if (p < 58) kind = clns_pkg::REQ_SET_CURSOR;
      else if (p < 64) kind = clns_pkg::REQ_CLEAR;
      else if (p < 90) kind = clns_pkg::REQ_CLEAR_ROW;
      else kind = 3'($urandom_range(5, 7));
      col = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(40, 63))
                                        : 6'($urandom_range(0, 39));
      send_request(kind, 8'($urandom), 1'($urandom), col);
      if (kind <= clns_pkg::REQ_CLEAR_ROW) done++;
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // reset width of 16 columns
    send_request(clns_pkg::REQ_INIT, 8'h00, 1'b0, 6'd0);
    send_request(clns_pkg::REQ_WRITE_CHAR, 8'h00, 1'b0, 6'd0);
    send_request(clns_pkg::REQ_WRITE_CHAR, 8'hFF, 1'b1, 6'd63);
    send_request(3'd5, 8'h00, 1'b0, 6'd0);
    send_request(3'd6, 8'hFF, 1'b1, 6'd63);
    send_request(3'd7, 8'h5A, 1'b0, 6'd21);
    send_request(clns_pkg::REQ_SET_CURSOR, 8'h00, 1'b1, 6'd39);
    send_request(clns_pkg::REQ_CLEAR_ROW, 8'h00, 1'b0, 6'd0);
    // cursor at the top of the address space, next character wraps to zero
    send_request(clns_pkg::REQ_SET_CURSOR, 8'h00, 1'b1, 6'd63);
    send_request(clns_pkg::REQ_WRITE_CHAR, 8'h41, 1'b0, 6'd0);
    send_request(clns_pkg::REQ_CLEAR_ROW, 8'h00, 1'b0, 6'd10);
    send_request(clns_pkg::REQ_CLEAR_ROW, 8'h00, 1'b0, 6'd16);
    send_request(clns_pkg::REQ_CLEAR_ROW, 8'h00, 1'b0, 6'd40);
    send_request(clns_pkg::REQ_CLEAR, 8'h00, 1'b0, 6'd0);
    send_request(clns_pkg::REQ_SET_CURSOR, 8'h00, 1'b0, 6'd0);
    settle();

    // wide rows: clear row is cut at sixteen spaces and resumed
    write_columns(6'd40);
    send_request(clns_pkg::REQ_CLEAR_ROW, 8'h00, 1'b0, 6'd0);
    send_request(clns_pkg::REQ_CLEAR_ROW, 8'h00, 1'b0, 6'd16);
    send_request(clns_pkg::REQ_CLEAR_ROW, 8'h00, 1'b0, 6'd32);
    send_request(clns_pkg::REQ_SET_CURSOR, 8'h00, 1'b1, 6'd5);
    send_request(clns_pkg::REQ_CLEAR_ROW, 8'h00, 1'b0, 6'd20);
    settle();

    write_columns(6'd1);
    send_request(clns_pkg::REQ_CLEAR_ROW, 8'h00, 1'b0, 6'd0);
    send_request(clns_pkg::REQ_CLEAR_ROW, 8'h00, 1'b0, 6'd1);
    send_request(clns_pkg::REQ_INIT, 8'h00, 1'b0, 6'd0);
    settle();

    write_columns(6'd40);
    run_random(52);
    settle();
    write_columns(6'd1);
    run_random(52);
    settle();
    write_columns(6'($urandom_range(2, 39)));
    run_random(52);
    settle();
    write_columns(6'd16);
    calm = 1'b1;
    run_random(52);
    settle();
    calm = 1'b0;
    write_columns(6'($urandom_range(1, 40)));
    run_random(52);
    settle();

    $display("run covered %0d init, %0d write, %0d cursor, %0d clear, %0d clear-row requests",
             sb.kind_count[clns_pkg::REQ_INIT], sb.kind_count[clns_pkg::REQ_WRITE_CHAR],
             sb.kind_count[clns_pkg::REQ_SET_CURSOR], sb.kind_count[clns_pkg::REQ_CLEAR],
             sb.kind_count[clns_pkg::REQ_CLEAR_ROW]);
    $display("plus %0d unknown kinds; %0d transfers checked over widths 1, 16, 40 and random",
             sb.kind_count[5] + sb.kind_count[6] + sb.kind_count[7], sb.xfers_checked);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
